// ===== hdl/iia_pkg.sv =====
package iia_pkg;

    localparam int DATA_WIDTH = 64;
    localparam int PORT_W     = 64;
    localparam int OP_W       = 4;
    localparam int HALF_LO    = DATA_WIDTH / 2;
    localparam int HALF_HI    = DATA_WIDTH - HALF_LO;
    localparam int PROD_W     = 2 * DATA_WIDTH;
    // partial products, product sum, sign and range check, corner min/max
    localparam int MUL_LAT    = 4;
    // one quotient bit per stage, then sign fix, then corner min/max
    localparam int DIV_LAT    = DATA_WIDTH + 2;
    localparam int MUL_DLY    = DIV_LAT - MUL_LAT;

    typedef logic signed [DATA_WIDTH-1:0] word_t;
    typedef logic [DATA_WIDTH-1:0]        mag_t;

    localparam word_t TMIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};
    localparam word_t TMAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};

    typedef enum logic [OP_W-1:0] {
        OP_ADD = 4'd0,
        OP_SUB = 4'd1,
        OP_MUL = 4'd2,
        OP_DIV = 4'd3,
        OP_MOD = 4'd4,
        OP_EQ  = 4'd5,
        OP_NE  = 4'd6,
        OP_GT  = 4'd7,
        OP_GE  = 4'd8,
        OP_LT  = 4'd9,
        OP_LE  = 4'd10,
        OP_NEG = 4'd11,
        OP_NOT = 4'd12
    } op_t;

    // operand magnitudes and signs handed to the corner units
    typedef struct packed {
        mag_t a0;
        mag_t a1;
        mag_t b0;
        mag_t b1;
        logic sa0;
        logic sa1;
        logic sb0;
        logic sb1;
    } opnd_t;

    typedef struct packed {
        logic  ok;
        word_t lo;
        word_t hi;
    } span_t;

    function automatic mag_t magnitude(input word_t x);
        return x[DATA_WIDTH-1] ? mag_t'(-x) : mag_t'(x);
    endfunction

    function automatic word_t smin(input word_t x, input word_t y);
        return (x < y) ? x : y;
    endfunction

    function automatic word_t smax(input word_t x, input word_t y);
        return (x > y) ? x : y;
    endfunction

endpackage

// ===== hdl/iia_mul.sv =====
module iia_mul
    import iia_pkg::*;
(
    input  logic  clk,
    input  logic  en,
    input  opnd_t opnd,
    output span_t span
);

    logic [3:0][2*HALF_LO-1:0]       ll_reg, ll_next;
    logic [3:0][HALF_LO+HALF_HI-1:0] lh_reg, lh_next;
    logic [3:0][HALF_LO+HALF_HI-1:0] hl_reg, hl_next;
    logic [3:0][2*HALF_HI-1:0]       hh_reg, hh_next;
    logic [3:0]                      neg1_reg, neg1_next;
    logic [3:0][PROD_W-1:0]          prod_reg, prod_next;
    logic [3:0]                      neg2_reg;
    word_t                           corner_reg [4];
    word_t                           corner_next [4];
    logic [3:0]                      cok_reg, cok_next;
    span_t                           span_reg, span_next;

    // corner order: a0*b0, a0*b1, a1*b0, a1*b1
    always_comb
    begin
        mag_t x;
        mag_t y;
        for (int i = 0; i < 4; i++)
        begin
            x = (i >= 2) ? opnd.a1 : opnd.a0;
            y = ((i & 1) != 0) ? opnd.b1 : opnd.b0;
            ll_next[i] = (2*HALF_LO)'(x[HALF_LO-1:0]) * (2*HALF_LO)'(y[HALF_LO-1:0]);
            lh_next[i] = (HALF_LO+HALF_HI)'(x[HALF_LO-1:0])
                       * (HALF_LO+HALF_HI)'(y[DATA_WIDTH-1:HALF_LO]);
            hl_next[i] = (HALF_LO+HALF_HI)'(x[DATA_WIDTH-1:HALF_LO])
                       * (HALF_LO+HALF_HI)'(y[HALF_LO-1:0]);
            hh_next[i] = (2*HALF_HI)'(x[DATA_WIDTH-1:HALF_LO])
                       * (2*HALF_HI)'(y[DATA_WIDTH-1:HALF_LO]);
            neg1_next[i] = ((i >= 2) ? opnd.sa1 : opnd.sa0)
                         ^ (((i & 1) != 0) ? opnd.sb1 : opnd.sb0);
        end
    end

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            prod_next[i] = (PROD_W'(hh_reg[i]) << (2*HALF_LO))
                         + ((PROD_W'(lh_reg[i]) + PROD_W'(hl_reg[i])) << HALF_LO)
                         + PROD_W'(ll_reg[i]);
        end
    end

    // a negative product may reach one past the positive limit
    always_comb
    begin
        logic [PROD_W-1:0] p;
        for (int i = 0; i < 4; i++)
        begin
            p = prod_reg[i];
            if (neg2_reg[i])
            begin
                cok_next[i]    = (p[PROD_W-1:DATA_WIDTH] == '0)
                               && !(p[DATA_WIDTH-1] && (p[DATA_WIDTH-2:0] != '0));
                corner_next[i] = -word_t'(p[DATA_WIDTH-1:0]);
            end
            else
            begin
                cok_next[i]    = (p[PROD_W-1:DATA_WIDTH-1] == '0);
                corner_next[i] = word_t'(p[DATA_WIDTH-1:0]);
            end
        end
    end

    always_comb
    begin
        span_next.ok = &cok_reg;
        span_next.lo = smin(smin(corner_reg[0], corner_reg[1]),
                            smin(corner_reg[2], corner_reg[3]));
        span_next.hi = smax(smax(corner_reg[0], corner_reg[1]),
                            smax(corner_reg[2], corner_reg[3]));
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ll_reg   <= ll_next;
            lh_reg   <= lh_next;
            hl_reg   <= hl_next;
            hh_reg   <= hh_next;
            neg1_reg <= neg1_next;
            prod_reg <= prod_next;
            neg2_reg <= neg1_reg;
            for (int i = 0; i < 4; i++)
            begin
                corner_reg[i] <= corner_next[i];
            end
            cok_reg  <= cok_next;
            span_reg <= span_next;
        end
    end

    assign span = span_reg;

endmodule

// ===== hdl/iia_div.sv =====
module iia_div
    import iia_pkg::*;
(
    input  logic  clk,
    input  logic  en,
    input  opnd_t opnd,
    output span_t span,
    output word_t rem0
);

    typedef struct packed {
        logic [3:0][DATA_WIDTH-1:0] rem;
        logic [3:0][DATA_WIDTH-1:0] quo;
        mag_t                       b0;
        mag_t                       b1;
        logic [3:0]                 qneg;
        logic                       sa0;
    } dstage_t;

    dstage_t    entry;
    dstage_t    stage_reg [1:DATA_WIDTH];
    word_t      corner_reg [4];
    word_t      corner_next [4];
    logic [3:0] cok_reg, cok_next;
    word_t      rem_reg, rem_next;
    word_t      rem_out_reg;
    span_t      span_reg, span_next;

    // one restoring step on all four corners
    function automatic dstage_t div_step(input dstage_t s);
        dstage_t             r;
        logic [DATA_WIDTH:0] tmp;
        logic [DATA_WIDTH:0] d;
        r = s;
        for (int i = 0; i < 4; i++)
        begin
            tmp = {s.rem[i], s.quo[i][DATA_WIDTH-1]};
            d   = {1'b0, ((i & 1) != 0) ? s.b1 : s.b0};
            r.quo[i] = {s.quo[i][DATA_WIDTH-2:0], 1'b0};
            if (tmp >= d)
            begin
                tmp         = tmp - d;
                r.quo[i][0] = 1'b1;
            end
            r.rem[i] = tmp[DATA_WIDTH-1:0];
        end
        return r;
    endfunction

    // corner order: a0/b0, a0/b1, a1/b0, a1/b1
    always_comb
    begin
        entry.b0  = opnd.b0;
        entry.b1  = opnd.b1;
        entry.sa0 = opnd.sa0;
        for (int i = 0; i < 4; i++)
        begin
            entry.rem[i]  = '0;
            entry.quo[i]  = (i >= 2) ? opnd.a1 : opnd.a0;
            entry.qneg[i] = ((i >= 2) ? opnd.sa1 : opnd.sa0)
                          ^ (((i & 1) != 0) ? opnd.sb1 : opnd.sb0);
        end
    end

    // a positive quotient with the top bit set is the most-negative by minus one case
    always_comb
    begin
        mag_t qm;
        for (int i = 0; i < 4; i++)
        begin
            qm             = stage_reg[DATA_WIDTH].quo[i];
            cok_next[i]    = stage_reg[DATA_WIDTH].qneg[i] || !qm[DATA_WIDTH-1];
            corner_next[i] = stage_reg[DATA_WIDTH].qneg[i] ? -word_t'(qm) : word_t'(qm);
        end
        rem_next = stage_reg[DATA_WIDTH].sa0 ? -word_t'(stage_reg[DATA_WIDTH].rem[0])
                                             : word_t'(stage_reg[DATA_WIDTH].rem[0]);
    end

    always_comb
    begin
        span_next.ok = &cok_reg;
        span_next.lo = smin(smin(corner_reg[0], corner_reg[1]),
                            smin(corner_reg[2], corner_reg[3]));
        span_next.hi = smax(smax(corner_reg[0], corner_reg[1]),
                            smax(corner_reg[2], corner_reg[3]));
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            stage_reg[1] <= div_step(entry);
            for (int k = 2; k <= DATA_WIDTH; k++)
            begin
                stage_reg[k] <= div_step(stage_reg[k-1]);
            end
            for (int i = 0; i < 4; i++)
            begin
                corner_reg[i] <= corner_next[i];
            end
            cok_reg     <= cok_next;
            rem_reg     <= rem_next;
            span_reg    <= span_next;
            rem_out_reg <= rem_reg;
        end
    end

    assign span = span_reg;
    assign rem0 = rem_out_reg;

endmodule

// ===== hdl/integer_interval_arithmetic.sv =====
// channel  direction  handshake                fields
// in       to block   in_valid / in_stall      req_type, a_min, a_max, b_min, b_max
// out      from block out_valid / out_stall    res_min, res_max
//
// one beat per cycle in and out unless the output stalls; at 64-bit width the path is
// input register, decode, 66 stages of the corner divider, output register
// the divider retires one quotient bit per stage and sets the depth
// rst_n clears only the valid bits, payload registers are not reset
// a stalled output freezes the whole pipeline; in_stall follows it in the same cycle
module integer_interval_arithmetic
    import iia_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [OP_W-1:0]       req_type,
    input  logic signed [PORT_W-1:0] a_min,
    input  logic signed [PORT_W-1:0] a_max,
    input  logic signed [PORT_W-1:0] b_min,
    input  logic signed [PORT_W-1:0] b_max,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic signed [PORT_W-1:0] res_min,
    output logic signed [PORT_W-1:0] res_max
);

    typedef struct packed {
        op_t   op;
        logic  full;
        logic  aconst;
        word_t lo;
        word_t hi;
    } ctx_t;

    logic                en;
    logic                s0_valid_reg;
    logic [OP_W-1:0]     op0_reg;
    word_t               a0_reg, a1_reg, b0_reg, b1_reg;
    logic                s1_valid_reg;
    ctx_t                ctx_reg, ctx_next;
    opnd_t               opnd_reg, opnd_next;
    logic [DIV_LAT-1:0]  vld_pipe_reg;
    ctx_t                ctx_pipe_reg [0:DIV_LAT-1];
    span_t               mul_pipe_reg [0:MUL_DLY-1];
    span_t               mul_span, div_span;
    word_t               div_rem;
    ctx_t                last;
    span_t               mul_last;
    logic                out_valid_reg;
    logic signed [PORT_W-1:0] res_min_reg, res_min_next;
    logic signed [PORT_W-1:0] res_max_reg, res_max_next;

    assign en       = !(out_valid_reg && out_stall);
    assign in_stall = !en;

    // decode: bound arithmetic, divide and modulo checks, comparisons and unary operations
    always_comb
    begin
        logic [DATA_WIDTH:0] slo;
        logic [DATA_WIDTH:0] shi;
        logic                dis;
        logic                same;
        logic                yes;
        logic                no;
        ctx_next.op     = op_t'(op0_reg);
        ctx_next.full   = 1'b0;
        ctx_next.aconst = (a0_reg == a1_reg);
        ctx_next.lo     = '0;
        ctx_next.hi     = '0;
        slo  = '0;
        shi  = '0;
        yes  = 1'b0;
        no   = 1'b0;
        dis  = (a1_reg < b0_reg) || (a0_reg > b1_reg);
        same = (a0_reg == a1_reg) && (b0_reg == b1_reg) && (a0_reg == b0_reg);
        unique case (op_t'(op0_reg))
            OP_ADD:
            begin
                slo = {a0_reg[DATA_WIDTH-1], a0_reg} + {b0_reg[DATA_WIDTH-1], b0_reg};
                shi = {a1_reg[DATA_WIDTH-1], a1_reg} + {b1_reg[DATA_WIDTH-1], b1_reg};
                ctx_next.full = (slo[DATA_WIDTH] != slo[DATA_WIDTH-1])
                             || (shi[DATA_WIDTH] != shi[DATA_WIDTH-1]);
                ctx_next.lo = word_t'(slo[DATA_WIDTH-1:0]);
                ctx_next.hi = word_t'(shi[DATA_WIDTH-1:0]);
            end
            OP_SUB:
            begin
                slo = {a0_reg[DATA_WIDTH-1], a0_reg} - {b1_reg[DATA_WIDTH-1], b1_reg};
                shi = {a1_reg[DATA_WIDTH-1], a1_reg} - {b0_reg[DATA_WIDTH-1], b0_reg};
                ctx_next.full = (slo[DATA_WIDTH] != slo[DATA_WIDTH-1])
                             || (shi[DATA_WIDTH] != shi[DATA_WIDTH-1]);
                ctx_next.lo = word_t'(slo[DATA_WIDTH-1:0]);
                ctx_next.hi = word_t'(shi[DATA_WIDTH-1:0]);
            end
            OP_MUL:
            begin
                ctx_next.full = 1'b0;
            end
            OP_DIV:
            begin
                // divisor range holding zero
                ctx_next.full = (b0_reg <= 0 && b1_reg >= 0) || (b0_reg == 0) || (b1_reg == 0);
            end
            OP_MOD:
            begin
                ctx_next.full = (b0_reg != b1_reg) || (b0_reg == 0)
                             || ((a0_reg != a1_reg) && (b0_reg == TMIN));
                ctx_next.hi   = b0_reg - word_t'(1);
            end
            OP_EQ, OP_NE, OP_GT, OP_GE, OP_LT, OP_LE:
            begin
                unique case (op_t'(op0_reg))
                    OP_EQ:
                    begin
                        yes = !dis && same;
                        no  = dis;
                    end
                    OP_NE:
                    begin
                        yes = dis;
                        no  = !dis && same;
                    end
                    OP_GT:
                    begin
                        yes = a0_reg > b1_reg;
                        no  = !(a0_reg > b1_reg) && (a1_reg <= b0_reg);
                    end
                    OP_GE:
                    begin
                        yes = a0_reg >= b1_reg;
                        no  = !(a0_reg >= b1_reg) && (a1_reg < b0_reg);
                    end
                    OP_LT:
                    begin
                        yes = a1_reg < b0_reg;
                        no  = !(a1_reg < b0_reg) && (a0_reg >= b1_reg);
                    end
                    default:
                    begin
                        yes = a1_reg <= b0_reg;
                        no  = !(a1_reg <= b0_reg) && (a0_reg > b1_reg);
                    end
                endcase
                ctx_next.lo = word_t'(yes);
                ctx_next.hi = word_t'(!no);
            end
            OP_NEG:
            begin
                ctx_next.full = (a0_reg == TMIN) || (a1_reg == TMIN);
                ctx_next.lo   = -a1_reg;
                ctx_next.hi   = -a0_reg;
            end
            OP_NOT:
            begin
                if (a0_reg == a1_reg)
                begin
                    ctx_next.lo = word_t'(a0_reg == 0);
                    ctx_next.hi = word_t'(a0_reg == 0);
                end
                else
                begin
                    ctx_next.lo = '0;
                    ctx_next.hi = word_t'(1);
                end
            end
            default:
            begin
                ctx_next.lo = '0;
                ctx_next.hi = '0;
            end
        endcase
    end

    always_comb
    begin
        opnd_next.a0  = magnitude(a0_reg);
        opnd_next.a1  = magnitude(a1_reg);
        opnd_next.b0  = magnitude(b0_reg);
        opnd_next.b1  = magnitude(b1_reg);
        opnd_next.sa0 = a0_reg[DATA_WIDTH-1];
        opnd_next.sa1 = a1_reg[DATA_WIDTH-1];
        opnd_next.sb0 = b0_reg[DATA_WIDTH-1];
        opnd_next.sb1 = b1_reg[DATA_WIDTH-1];
    end

    iia_mul u_mul
    (
        .clk  (clk),
        .en   (en),
        .opnd (opnd_reg),
        .span (mul_span)
    );

    iia_div u_div
    (
        .clk  (clk),
        .en   (en),
        .opnd (opnd_reg),
        .span (div_span),
        .rem0 (div_rem)
    );

    assign last     = ctx_pipe_reg[DIV_LAT-1];
    assign mul_last = mul_pipe_reg[MUL_DLY-1];

    // merge the unit results with the decoded ones
    always_comb
    begin
        logic  full;
        word_t lo;
        word_t hi;
        full = last.full;
        lo   = last.lo;
        hi   = last.hi;
        unique case (last.op)
            OP_MUL:
            begin
                full = !mul_last.ok;
                lo   = mul_last.lo;
                hi   = mul_last.hi;
            end
            OP_DIV:
            begin
                full = last.full || !div_span.ok;
                lo   = div_span.lo;
                hi   = div_span.hi;
            end
            OP_MOD:
            begin
                if (last.aconst)
                begin
                    lo = div_rem;
                    hi = div_rem;
                end
                else
                begin
                    lo = (div_rem < 0) ? div_rem : '0;
                    hi = last.hi;
                end
            end
            default:
            begin
                full = last.full;
            end
        endcase
        if (full)
        begin
            lo = TMIN;
            hi = TMAX;
        end
        res_min_next = PORT_W'(lo);
        res_max_next = PORT_W'(hi);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg  <= 1'b0;
            s1_valid_reg  <= 1'b0;
            vld_pipe_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s0_valid_reg  <= in_valid;
            s1_valid_reg  <= s0_valid_reg;
            vld_pipe_reg  <= {vld_pipe_reg[DIV_LAT-2:0], s1_valid_reg};
            out_valid_reg <= vld_pipe_reg[DIV_LAT-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            op0_reg  <= req_type;
            a0_reg   <= word_t'(a_min[DATA_WIDTH-1:0]);
            a1_reg   <= word_t'(a_max[DATA_WIDTH-1:0]);
            b0_reg   <= word_t'(b_min[DATA_WIDTH-1:0]);
            b1_reg   <= word_t'(b_max[DATA_WIDTH-1:0]);
            ctx_reg  <= ctx_next;
            opnd_reg <= opnd_next;
            ctx_pipe_reg[0] <= ctx_reg;
            for (int k = 1; k < DIV_LAT; k++)
            begin
                ctx_pipe_reg[k] <= ctx_pipe_reg[k-1];
            end
            mul_pipe_reg[0] <= mul_span;
            for (int k = 1; k < MUL_DLY; k++)
            begin
                mul_pipe_reg[k] <= mul_pipe_reg[k-1];
            end
            res_min_reg <= res_min_next;
            res_max_reg <= res_max_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign res_min   = res_min_reg;
    assign res_max   = res_max_reg;

    a_cmp_bool: assert property (@(posedge clk) disable iff (!rst_n)
        (en && vld_pipe_reg[DIV_LAT-1]
            && (last.op == OP_EQ || last.op == OP_NE || last.op == OP_GT
                || last.op == OP_GE || last.op == OP_LT || last.op == OP_LE))
        |=> (res_min_reg[PORT_W-1:1] == '0) && (res_max_reg[PORT_W-1:1] == '0)
            && !(res_min_reg[0] && !res_max_reg[0]))
        else $error("comparison result is not a 0/1 range");

    a_div_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (en && vld_pipe_reg[DIV_LAT-1] && last.op == OP_DIV && last.full)
        |=> (res_min_reg == PORT_W'(TMIN)) && (res_max_reg == PORT_W'(TMAX)))
        else $error("divisor range holding zero did not give the full range");

    a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
        (en && vld_pipe_reg[DIV_LAT-1]) |=> out_valid_reg)
        else $error("finished beat did not reach the output register");

endmodule
